### design/idc_pkg.sv
// shared types and constants of the idle injection duty controller
package idc_pkg;

   localparam int LEVEL_W  = 7;
   localparam int IDLE_W   = 20;
   localparam int RUN_W    = 27;
   localparam int QW_LONG  = 27;
   localparam int QW_SHORT = 7;
   localparam int CNT_W    = 5;
   localparam int RSP_BITS = RUN_W + 4 + LEVEL_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [LEVEL_W-1:0] PCT_FULL   = 7'd100;
   localparam logic [IDLE_W-1:0]  IDLE_RESET = 20'd24000;
   localparam logic [LEVEL_W-1:0] HYST_RESET = 7'd5;

   // configuration register indexes
   localparam logic CSR_IDLE_TIME  = 1'b0;
   localparam logic CSR_HYSTERESIS = 1'b1;

   // item kinds
   localparam logic ACT_SET_LEVEL = 1'b0;
   localparam logic ACT_SAMPLE    = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BUSY_WAIT,
      ST_DECIDE,
      ST_RUN_WAIT,
      ST_FINISH
   } ctrl_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_PRE1,
      DIV_PRE2,
      DIV_ITER
   } div_state_type;

   typedef struct packed {
      logic start;
      logic long_mode;
   } div_ctl_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] effective_idle;
      logic               compensating;
      logic               stop_injection;
      logic               start_injection;
      logic               program_duration;
      logic [RUN_W-1:0]   run_us;
   } result_type;

endpackage

### design/idc_div.sv
// shared scaled divider: floor(x * 100 / d) through one adder, one quotient bit a cycle
module idc_div import idc_pkg::*; #(
   parameter int COUNTER_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  div_ctl_type             ctl,
   input  logic [COUNTER_BITS-1:0] x,
   input  logic [COUNTER_BITS-1:0] d,
   output logic                    done,
   output logic [QW_LONG-1:0]      quo
);

   localparam int RW = COUNTER_BITS + 7;

   div_state_type            state_ff, state_in;
   logic [RW-1:0]            rem_ff, rem_in;
   logic [RW-1:0]            dsh_ff, dsh_in;
   logic [COUNTER_BITS-1:0]  x_ff, x_in;
   logic [QW_LONG-1:0]       quo_ff, quo_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     done_ff, done_in;
   logic [RW-1:0]            add_b;
   logic                     add_cin;
   logic [RW:0]              sum;

   // the one adder: pre-scale by 64 + 32 + 4, then trial subtracts
   always_comb begin
      add_b   = '0;
      add_cin = 1'b0;
      unique case (state_ff)
         DIV_PRE1: add_b = {2'b0, x_ff, 5'b0};
         DIV_PRE2: add_b = {5'b0, x_ff, 2'b0};
         DIV_ITER: begin
            add_b   = ~dsh_ff;
            add_cin = 1'b1;
         end
         default:  add_b = '0;
      endcase
      sum = {1'b0, rem_ff} + {1'b0, add_b} + {{RW{1'b0}}, add_cin};
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      x_in     = x_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         DIV_IDLE: begin
            if (ctl.start) begin
               x_in   = x;
               rem_in = {1'b0, x, 6'b0};
               quo_in = '0;
               if (ctl.long_mode) begin
                  dsh_in = RW'({7'b0, d} << (QW_LONG - 1));
                  cnt_in = CNT_W'(QW_LONG);
               end else begin
                  dsh_in = RW'({7'b0, d} << (QW_SHORT - 1));
                  cnt_in = CNT_W'(QW_SHORT);
               end
               state_in = DIV_PRE1;
            end
         end
         DIV_PRE1: begin
            rem_in   = sum[RW-1:0];
            state_in = DIV_PRE2;
         end
         DIV_PRE2: begin
            rem_in   = sum[RW-1:0];
            state_in = DIV_ITER;
         end
         DIV_ITER: begin
            // carry out means the remainder covers the shifted divisor
            if (sum[RW]) begin
               rem_in = sum[RW-1:0];
            end
            quo_in = {quo_ff[QW_LONG-2:0], sum[RW]};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               done_in  = 1'b1;
               state_in = DIV_IDLE;
            end
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      x_ff   <= x_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

### design/idc_ctrl.sv
// sequencer and controller state: level, sample history, compensation decision
module idc_ctrl import idc_pkg::*; #(
   parameter int COUNTER_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    action,
   input  logic [LEVEL_W-1:0]      new_level,
   input  logic [COUNTER_BITS-1:0] tsc_now,
   input  logic [COUNTER_BITS-1:0] mperf_now,
   input  logic [IDLE_W-1:0]       idle_time,
   input  logic [LEVEL_W-1:0]      hyst,
   input  logic                    out_free,
   output logic                    res_load,
   output result_type              res,
   output div_ctl_type             div_ctl,
   output logic [COUNTER_BITS-1:0] div_x,
   output logic [COUNTER_BITS-1:0] div_d,
   input  logic                    div_done,
   input  logic [QW_LONG-1:0]      div_quo
);

   ctrl_state_type           state_ff, state_in;
   logic [LEVEL_W-1:0]       level_ff, level_in;
   logic [RUN_W-1:0]         nominal_ff, nominal_in;
   logic                     comp_ff, comp_in;
   logic [COUNTER_BITS-1:0]  prev_tsc_ff, prev_tsc_in;
   logic [COUNTER_BITS-1:0]  prev_mperf_ff, prev_mperf_in;
   logic                     sv_ff, sv_in;
   logic [LEVEL_W-1:0]       held_ff, held_in;
   logic [COUNTER_BITS-1:0]  dt_ff, dt_in;
   logic [COUNTER_BITS-1:0]  dm_ff, dm_in;
   logic [LEVEL_W-1:0]       eff_ff, eff_in;
   logic [RUN_W-1:0]         run_ff, run_in;
   logic                     prog_ff, prog_in;
   logic                     start_ff, start_in;
   logic                     stop_ff, stop_in;
   logic                     nom_ff, nom_in;
   logic [LEVEL_W-1:0]       nl_sat;
   logic signed [LEVEL_W:0]  lim;

   always_comb begin
      nl_sat = (new_level > PCT_FULL) ? PCT_FULL : new_level;
      lim    = signed'({1'b0, level_ff}) - signed'({1'b0, hyst});

      state_in      = state_ff;
      level_in      = level_ff;
      nominal_in    = nominal_ff;
      comp_in       = comp_ff;
      prev_tsc_in   = prev_tsc_ff;
      prev_mperf_in = prev_mperf_ff;
      sv_in         = sv_ff;
      held_in       = held_ff;
      dt_in         = dt_ff;
      dm_in         = dm_ff;
      eff_in        = eff_ff;
      run_in        = run_ff;
      prog_in       = prog_ff;
      start_in      = start_ff;
      stop_in       = stop_ff;
      nom_in        = nom_ff;
      res_load      = 1'b0;
      div_ctl       = '0;
      div_x         = '0;
      div_d         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               run_in   = '0;
               prog_in  = 1'b0;
               start_in = 1'b0;
               stop_in  = 1'b0;
               if (action == ACT_SET_LEVEL) begin
                  level_in = nl_sat;
                  nom_in   = 1'b1;
                  if (level_ff == '0 && nl_sat != '0) begin
                     // leaving level zero drops the stored sample
                     start_in      = 1'b1;
                     sv_in         = 1'b0;
                     prev_tsc_in   = '0;
                     prev_mperf_in = '0;
                  end else if (level_ff != '0 && nl_sat == '0) begin
                     stop_in = 1'b1;
                  end
                  if (nl_sat != '0) begin
                     prog_in           = 1'b1;
                     div_ctl.start     = 1'b1;
                     div_ctl.long_mode = 1'b1;
                     div_x    = {{(COUNTER_BITS-IDLE_W){1'b0}}, idle_time};
                     div_d    = {{(COUNTER_BITS-LEVEL_W){1'b0}}, nl_sat};
                     state_in = ST_RUN_WAIT;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end else begin
                  nom_in        = 1'b0;
                  dt_in         = tsc_now - prev_tsc_ff;
                  dm_in         = mperf_now - prev_mperf_ff;
                  prev_tsc_in   = tsc_now;
                  prev_mperf_in = mperf_now;
                  sv_in         = 1'b1;
                  state_in      = sv_ff ? ST_CHECK : ST_FINISH;
               end
            end
         end
         ST_CHECK: begin
            if (dt_ff == '0) begin
               state_in = ST_FINISH;
            end else if (dm_ff >= dt_ff) begin
               eff_in   = '0;
               state_in = ST_DECIDE;
            end else begin
               div_ctl.start = 1'b1;
               div_x         = dm_ff;
               div_d         = dt_ff;
               state_in      = ST_BUSY_WAIT;
            end
         end
         ST_BUSY_WAIT: begin
            if (div_done) begin
               eff_in   = PCT_FULL - div_quo[QW_SHORT-1:0];
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            held_in = eff_ff;
            if (lim > signed'({1'b0, eff_ff})) begin
               comp_in = 1'b1;
               prog_in = 1'b1;
               if (eff_ff != '0) begin
                  div_ctl.start     = 1'b1;
                  div_ctl.long_mode = 1'b1;
                  div_x    = {{(COUNTER_BITS-IDLE_W){1'b0}}, idle_time};
                  div_d    = {{(COUNTER_BITS-LEVEL_W){1'b0}}, eff_ff};
                  state_in = ST_RUN_WAIT;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (comp_ff) begin
               // withdraw compensation
               run_in   = nominal_ff;
               prog_in  = 1'b1;
               comp_in  = 1'b0;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_RUN_WAIT: begin
            if (div_done) begin
               run_in = div_quo - {{(RUN_W-IDLE_W){1'b0}}, idle_time};
               if (nom_ff) begin
                  nominal_in = run_in;
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         level_ff      <= '0;
         nominal_ff    <= '0;
         comp_ff       <= 1'b0;
         prev_tsc_ff   <= '0;
         prev_mperf_ff <= '0;
         sv_ff         <= 1'b0;
         held_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         level_ff      <= level_in;
         nominal_ff    <= nominal_in;
         comp_ff       <= comp_in;
         prev_tsc_ff   <= prev_tsc_in;
         prev_mperf_ff <= prev_mperf_in;
         sv_ff         <= sv_in;
         held_ff       <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff    <= dt_in;
      dm_ff    <= dm_in;
      eff_ff   <= eff_in;
      run_ff   <= run_in;
      prog_ff  <= prog_in;
      start_ff <= start_in;
      stop_ff  <= stop_in;
      nom_ff   <= nom_in;
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      res.run_us           = prog_ff ? run_ff : '0;
      res.program_duration = prog_ff;
      res.start_injection  = start_ff;
      res.stop_injection   = stop_ff;
      res.compensating     = comp_ff;
      res.effective_idle   = held_ff;
   end

`ifndef SYNTHESIS
   a_done_when_waiting : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_BUSY_WAIT || state_ff == ST_RUN_WAIT))
      else $error("divider finished outside a wait state");
   a_accept_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("still ready after taking a word");
   a_comp_from_decide : assert property (@(posedge clock) disable iff (reset)
      $rose(comp_ff) |-> $past(state_ff) == ST_DECIDE)
      else $error("compensation engaged outside the decision step");
   a_held_in_range : assert property (@(posedge clock) disable iff (reset)
      held_ff <= PCT_FULL)
      else $error("effective idle above full scale");
`endif

endmodule

### design/idle_injection_duty_controller_top.sv
// top level: stream ports, configuration registers, result register
// a nonzero level word runs the divider once for its run time, a sample word up to twice, other words
//   not at all; a divider pass runs PRE1 and PRE2 pre-scale, 7 or 27 quotient bits, then done
// throughput: one word at a time, the next taken the cycle after its result is loaded, so a
//   stalled result holds back only the word after next
// reset: synchronous, active high; clears state and the output valid flag, loads 24000 us and 5 pct
module idle_injection_duty_controller_top import idc_pkg::*; #(
   parameter int COUNTER_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // new_level [6:0], tsc_now, mperf_now, zero pad
   input  logic [((LEVEL_W + 2*COUNTER_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // action
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // run_us, program_duration, start_injection, stop_injection, compensating,
   // effective_idle, zero pad
   output logic [RSP_W-1:0]         rsp_tdata,
   input  logic                     csr_we,
   input  logic                     csr_addr,
   input  logic [IDLE_W-1:0]        csr_wdata
);

   logic [IDLE_W-1:0]        idle_time_ff;
   logic [LEVEL_W-1:0]       hyst_ff;
   logic                     rsp_valid_ff;
   logic [RSP_W-1:0]         rsp_data_ff;
   logic                     out_free;
   logic                     res_load;
   result_type               res;
   div_ctl_type              div_ctl;
   logic [COUNTER_BITS-1:0]  div_x;
   logic [COUNTER_BITS-1:0]  div_d;
   logic                     div_done;
   logic [QW_LONG-1:0]       div_quo;

   // configuration registers, to be written only while idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_time_ff <= IDLE_RESET;
         hyst_ff      <= HYST_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_IDLE_TIME:  idle_time_ff <= csr_wdata;
            CSR_HYSTERESIS: hyst_ff      <= csr_wdata[LEVEL_W-1:0];
            default:        idle_time_ff <= idle_time_ff;
         endcase
      end
   end

   // output register frees the sequencer while a result waits
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= {{(RSP_W-RSP_BITS){1'b0}}, res};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sequencer with the controller state
   idc_ctrl #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .action    (req_tuser),
      .new_level (req_tdata[LEVEL_W-1:0]),
      .tsc_now   (req_tdata[LEVEL_W +: COUNTER_BITS]),
      .mperf_now (req_tdata[LEVEL_W + COUNTER_BITS +: COUNTER_BITS]),
      .idle_time (idle_time_ff),
      .hyst      (hyst_ff),
      .out_free  (out_free),
      .res_load  (res_load),
      .res       (res),
      .div_ctl   (div_ctl),
      .div_x     (div_x),
      .div_d     (div_d),
      .div_done  (div_done),
      .div_quo   (div_quo)
   );

   // shared divider for both run time and busy percentage
   idc_div #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .x     (div_x),
      .d     (div_d),
      .done  (div_done),
      .quo   (div_quo)
   );

endmodule
